FILE: rtl/lfc_pkg.sv
// Shared constants and types for the lookahead feedforward compressor.
package lfc_pkg;

    localparam int unsigned DbFloor     = 35840;
    localparam logic [14:0] DbPerLog2   = 15'd24660;
    localparam logic [13:0] Log2PerDb   = 14'd10885;
    localparam logic [16:0] Unity       = 17'd65536;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SLOPE     = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_RELEASE   = 3'd3;
    localparam logic [2:0] REG_LOOKAHEAD = 3'd4;
    localparam logic [2:0] REG_WET       = 3'd5;

    typedef struct packed {
        logic [15:0] threshold_db;
        logic [15:0] slope;
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic [12:0] lookahead_samples;
        logic [16:0] wet_fraction;
    } t_cfg;

    function automatic logic [15:0] exp_frac(input logic [2:0] k);
        logic [15:0] v;
        case (k)
            3'd0:    v = 16'd65358;
            3'd1:    v = 16'd65181;
            3'd2:    v = 16'd64830;
            3'd3:    v = 16'd64132;
            3'd4:    v = 16'd62757;
            3'd5:    v = 16'd60097;
            3'd6:    v = 16'd55109;
            default: v = 16'd46341;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/lfc_delay.sv
// Delay line memory with one write port and one registered read port.
module lfc_delay #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/lookahead_feedforward_compressor.sv
// Top level of the lookahead feedforward compressor.
//
// One signed sample enters on the i_sample_in valid/ready request channel; one
// result (sample_out, gain_out) leaves on the o_ valid/ready channel per
// request. Configuration is written with i_cfg_we, i_cfg_index, i_cfg_data;
// the user must write it only while idle, which the block does not enforce.
// The envelope update, twelve squaring rounds of the log, eight exponent
// steps and four mix products all go through one shared signed 26x26
// multiplier, one product per cycle. The next request is taken only after
// the block has loaded the last result and returned to idle. Silence skips
// the log and a level at or under the threshold skips the exponent. The
// delay line is a block memory with a registered read. After reset the block
// sweeps zeros into the whole delay line, one entry per cycle, before it
// accepts the first request; configuration writes are taken during the
// sweep. The result sits in an output register; while the receiver stalls,
// the next request is accepted and processed, then waits until the output
// register is free.
module lookahead_feedforward_compressor #(
    parameter int DELAY_DEPTH = 8192,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic [16:0]            o_gain_out,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [16:0]            i_cfg_data
);
    import lfc_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int ES = 24 - SAMPLE_BITS;
    localparam int WW = SAMPLE_BITS + 18;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ENV   = 4'd2;
    localparam logic [3:0] S_LOGP  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_DB    = 4'd5;
    localparam logic [3:0] S_RED   = 4'd6;
    localparam logic [3:0] S_EXP1  = 4'd7;
    localparam logic [3:0] S_EXPK  = 4'd8;
    localparam logic [3:0] S_MIX1  = 4'd9;
    localparam logic [3:0] S_MIX2  = 4'd10;
    localparam logic [3:0] S_MIX3  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_THR   = 4'd13;
    localparam logic [3:0] S_MIX4  = 4'd14;
    localparam logic [3:0] S_MIX5  = 4'd15;

    t_cfg r_cfg;
    logic [3:0]  r_state;
    logic [AW-1:0] r_wp, r_clr;
    logic [23:0] r_env;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [4:0]  r_p;
    logic [17:0] r_m;
    logic [11:0] r_frac;
    logic [3:0]  r_cnt;
    logic signed [17:0] r_lvl;
    logic [15:0] r_e;
    logic [16:0] r_gain;
    logic [16:0] r_w;
    logic signed [63:0] r_acc;
    logic signed [WW-1:0] r_wd;
    logic signed [SAMPLE_BITS-1:0] r_dly;
    logic        r_ovalid;

    // Shared signed 26x26 multiplier; unsigned operands are zero-extended.
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Product rounded to nearest and scaled down by 2^16.
    logic signed [51:0] rnd_p;
    assign rnd_p = (mul_p + 52'sd32768) >>> 16;

    logic [SAMPLE_BITS-1:0] rdata;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    lfc_delay #(.DEPTH(DELAY_DEPTH), .AW(AW), .DW(SAMPLE_BITS)) u_delay (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(rdata)
    );

    logic accept;
    logic out_load;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    logic [AW-1:0] la;
    assign la = AW'(r_cfg.lookahead_samples);
    assign mem_raddr = r_wp - la;
    assign mem_we    = (r_state == S_CLEAR) || accept;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : r_wp;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : i_sample_in;

    logic [23:0] a_abs;
    logic [SAMPLE_BITS-1:0] xabs;
    assign xabs  = r_x[SAMPLE_BITS-1] ? -r_x : r_x;
    assign a_abs = 24'(xabs) << ES;
    logic [16:0] c_sel;
    assign c_sel = {1'b0, (a_abs > r_env) ? r_cfg.attack_coeff : r_cfg.release_coeff};

    logic [4:0] lead;
    always_comb begin
        lead = '0;
        for (int i = 0; i < 24; i++) begin
            if (r_env[i]) lead = 5'(i);
        end
    end

    logic [2:0] kidx;
    assign kidx = r_cnt[2:0];

    logic [16:0] n_num;
    assign n_num = {5'd23 - r_p, 12'd0} - {5'd0, r_frac};

    // Multiplier operand selection per state.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ENV: begin
                mul_a = 26'(a_abs);
                mul_b = 26'(Unity - c_sel);
            end
            S_LOGP: begin
                mul_a = 26'(r_env);
                mul_b = 26'(c_sel);
            end
            S_SQ: begin
                mul_a = 26'(r_m);
                mul_b = 26'(r_m);
            end
            S_DB: begin
                mul_a = 26'(n_num);
                mul_b = 26'(DbPerLog2);
            end
            S_EXP1: begin
                // The first pass scales the excess by the slope, the second
                // converts the reduction to log2 units.
                if (r_cnt == 4'd15) begin
                    mul_a = 26'(r_e);
                    mul_b = 26'(Log2PerDb);
                end else begin
                    mul_a = 26'(r_lvl);
                    mul_b = 26'(r_cfg.slope);
                end
            end
            S_EXPK: begin
                mul_a = 26'(r_gain);
                mul_b = 26'(exp_frac(kidx));
            end
            S_MIX1: begin
                mul_a = 26'(Unity - r_w);
                mul_b = 26'(r_x);
            end
            S_MIX2: begin
                mul_a = 26'(r_w);
                mul_b = 26'(r_dly);
            end
            S_MIX4: begin
                mul_a = 26'(r_wd[15:0]);
                mul_b = 26'(r_gain);
            end
            S_MIX5: begin
                mul_a = 26'(signed'(r_wd[WW-1:16]));
                mul_b = 26'(r_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic [33:0] sq_p;
    assign sq_p = mul_p[49:16];
    logic signed [17:0] thr_s;
    assign thr_s = 18'(signed'(r_cfg.threshold_db));
    logic signed [63:0] y_full;
    assign y_full = (r_acc + 64'sd2147483648) >>> 32;
    localparam logic signed [63:0] YMax = 64'sd2 ** (SAMPLE_BITS - 1) - 64'sd1;
    localparam logic signed [63:0] YMin = -(64'sd2 ** (SAMPLE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wp     <= '0;
            r_env    <= '0;
            r_ovalid <= 1'b0;
            r_cfg.threshold_db      <= 16'hEC00;
            r_cfg.slope             <= 16'd49152;
            r_cfg.attack_coeff      <= 16'd64684;
            r_cfg.release_coeff     <= 16'd65450;
            r_cfg.lookahead_samples <= 13'd240;
            r_cfg.wet_fraction      <= 17'd65536;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESHOLD: r_cfg.threshold_db      <= i_cfg_data[15:0];
                    REG_SLOPE:     r_cfg.slope             <= i_cfg_data[15:0];
                    REG_ATTACK:    r_cfg.attack_coeff      <= i_cfg_data[15:0];
                    REG_RELEASE:   r_cfg.release_coeff     <= i_cfg_data[15:0];
                    REG_LOOKAHEAD: r_cfg.lookahead_samples <= i_cfg_data[12:0];
                    REG_WET:       r_cfg.wet_fraction      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DELAY_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_x     <= i_sample_in;
                        r_wp    <= r_wp + 1'b1;
                        r_w     <= (r_cfg.wet_fraction > Unity) ? Unity : r_cfg.wet_fraction;
                        r_state <= S_ENV;
                    end
                end
                S_ENV: begin
                    r_dly   <= rdata;
                    r_acc   <= 64'(mul_p) + 64'sd32768;
                    r_state <= S_LOGP;
                end
                S_LOGP: begin
                    // Second envelope product lands here; log setup next pass.
                    r_env   <= 24'((r_acc + 64'(mul_p)) >>> 16);
                    r_state <= S_THR;
                end
                S_THR: begin
                    r_frac <= '0;
                    r_cnt  <= '0;
                    r_p    <= lead;
                    r_m    <= 18'(({r_env, 16'd0}) >> lead);
                    if (r_env == '0) begin
                        r_lvl   <= -18'sd35840;
                        r_state <= S_RED;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (sq_p >= 34'd131072) begin
                        r_m    <= 18'(sq_p >> 1);
                        r_frac <= {r_frac[10:0], 1'b1};
                    end else begin
                        r_m    <= 18'(sq_p);
                        r_frac <= {r_frac[10:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd11) begin
                        // Pack n = (23-p)*4096 - frac for the dB product.
                        r_state <= S_DB;
                    end
                end
                S_DB: begin
                    r_lvl   <= -$signed({1'b0, rnd_p[16:0]});
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_lvl > thr_s) begin
                        r_lvl   <= r_lvl - thr_s;
                        r_state <= S_EXP1;
                        r_e     <= '0;
                    end else begin
                        r_gain  <= Unity;
                        r_state <= S_MIX1;
                    end
                end
                S_EXP1: begin
                    if (r_cnt != 4'd15) begin
                        // First pass: reduction = diff*slope rounded.
                        r_e     <= rnd_p[15:0];
                        r_cnt   <= 4'd15;
                    end else begin
                        r_e     <= rnd_p[15:0];
                        r_gain  <= Unity;
                        r_cnt   <= 4'd7;
                        r_state <= S_EXPK;
                    end
                end
                S_EXPK: begin
                    if (r_e[kidx]) r_gain <= rnd_p[16:0];
                    if (r_cnt[2:0] == 3'd0) r_state <= S_MIX3;
                    else r_cnt <= r_cnt - 1'b1;
                end
                S_MIX3: begin
                    if (r_e[15:8] >= 8'd17) r_gain <= '0;
                    else r_gain <= r_gain >> r_e[12:8];
                    r_state <= S_MIX1;
                end
                S_MIX1: begin
                    r_acc   <= 64'(mul_p) <<< 16;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_wd    <= WW'(mul_p);
                    r_state <= S_MIX4;
                end
                S_MIX4: begin
                    // The wet product times the gain is taken in two halves.
                    r_acc   <= r_acc + 64'(mul_p);
                    r_state <= S_MIX5;
                end
                S_MIX5: begin
                    r_acc   <= r_acc + (64'(mul_p) <<< 16);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Round, saturate and deliver once the output is free.
                    if (out_load) begin
                        if (y_full > YMax) o_sample_out <= SAMPLE_BITS'(YMax);
                        else if (y_full < YMin) o_sample_out <= SAMPLE_BITS'(YMin);
                        else o_sample_out <= SAMPLE_BITS'(y_full);
                        o_gain_out <= r_gain;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
